// ===== sv/kdfa_pkg.sv =====
// ----------------------------------------------------------------------------
// kdfa_pkg: shared types, codes and keyword trie of the keyword tokenizer
// Holds the scan state codes, token kinds, character codes, the keyword trie
// as constant tables, and the token record that travels from scanner to queue.
// ----------------------------------------------------------------------------
package kdfa_pkg;

   // Field widths.
   localparam int STATE_W  = 7;
   localparam int KIND_W   = 6;
   localparam int INT_W    = 31;
   localparam int FRAC_W   = 30;
   localparam int FCNT_W   = 4;
   localparam int LINE_W   = 24;
   localparam int BAD_W    = 9;
   localparam int SYM_W    = 9;
   localparam int NODE_W   = 6;
   localparam int TRIE_N   = 58;
   localparam int FRAC_DIGITS_MAX = 9;
   localparam int MAX_TOK  = 3;

   // Token queue geometry.
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = 2;
   localparam int QCNT_W   = 3;

   localparam logic [INT_W-1:0]  INT_MAX  = '1;
   localparam logic [LINE_W-1:0] LINE_MAX = '1;

   // Scan states.
   localparam logic [STATE_W-1:0] S_START    = 7'd0;
   localparam logic [STATE_W-1:0] S_STRING   = 7'd1;
   localparam logic [STATE_W-1:0] S_INT      = 7'd2;
   localparam logic [STATE_W-1:0] S_INT_DOT  = 7'd3;
   localparam logic [STATE_W-1:0] S_FRAC     = 7'd4;
   localparam logic [STATE_W-1:0] S_IDENT    = 7'd5;
   localparam logic [STATE_W-1:0] S_EQ       = 7'd6;
   localparam logic [STATE_W-1:0] S_BANG     = 7'd7;
   localparam logic [STATE_W-1:0] S_GT       = 7'd8;
   localparam logic [STATE_W-1:0] S_LT       = 7'd9;
   localparam logic [STATE_W-1:0] S_SLASH    = 7'd10;
   localparam logic [STATE_W-1:0] S_LINE_CMT = 7'd11;
   localparam logic [STATE_W-1:0] S_BLK      = 7'd12;
   localparam logic [STATE_W-1:0] S_BLK_STAR = 7'd13;
   localparam logic [STATE_W-1:0] S_PLUS     = 7'd14;
   localparam logic [STATE_W-1:0] S_MINUS    = 7'd15;
   localparam logic [STATE_W-1:0] S_STAR     = 7'd16;
   localparam logic [STATE_W-1:0] S_BSLASH   = 7'd17;
   localparam logic [STATE_W-1:0] S_TRIE     = 7'd18;
   localparam logic [STATE_W-1:0] S_TRIE_END = 7'd76;

   // Token kinds.
   localparam logic [KIND_W-1:0] K_NEWLINE = 6'd0;
   localparam logic [KIND_W-1:0] K_STRING  = 6'd1;
   localparam logic [KIND_W-1:0] K_INTEGER = 6'd2;
   localparam logic [KIND_W-1:0] K_DECIMAL = 6'd3;
   localparam logic [KIND_W-1:0] K_IDENT   = 6'd4;
   localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd22;
   localparam logic [KIND_W-1:0] K_EQ      = 6'd23;
   localparam logic [KIND_W-1:0] K_NE      = 6'd24;
   localparam logic [KIND_W-1:0] K_GT      = 6'd25;
   localparam logic [KIND_W-1:0] K_GE      = 6'd26;
   localparam logic [KIND_W-1:0] K_LT      = 6'd27;
   localparam logic [KIND_W-1:0] K_LE      = 6'd28;
   localparam logic [KIND_W-1:0] K_DIV     = 6'd29;
   localparam logic [KIND_W-1:0] K_DIV_EQ  = 6'd30;
   localparam logic [KIND_W-1:0] K_ADD     = 6'd31;
   localparam logic [KIND_W-1:0] K_ADD_EQ  = 6'd32;
   localparam logic [KIND_W-1:0] K_SUB     = 6'd33;
   localparam logic [KIND_W-1:0] K_SUB_EQ  = 6'd34;
   localparam logic [KIND_W-1:0] K_MUL     = 6'd35;
   localparam logic [KIND_W-1:0] K_MUL_EQ  = 6'd36;
   localparam logic [KIND_W-1:0] K_LPAR    = 6'd37;
   localparam logic [KIND_W-1:0] K_RPAR    = 6'd38;
   localparam logic [KIND_W-1:0] K_LBRK    = 6'd39;
   localparam logic [KIND_W-1:0] K_RBRK    = 6'd40;
   localparam logic [KIND_W-1:0] K_LBRACE  = 6'd41;
   localparam logic [KIND_W-1:0] K_RBRACE  = 6'd42;
   localparam logic [KIND_W-1:0] K_DOT     = 6'd43;
   localparam logic [KIND_W-1:0] K_COMMA   = 6'd44;
   localparam logic [KIND_W-1:0] K_COLON   = 6'd45;
   localparam logic [KIND_W-1:0] K_SEMI    = 6'd46;
   localparam logic [KIND_W-1:0] K_EOS     = 6'd47;
   localparam logic [KIND_W-1:0] K_ERROR   = 6'd48;

   // Character codes on the 9-bit symbol (bit 8 marks end of input).
   localparam logic [SYM_W-1:0] CH_EOI   = 9'h100;
   localparam logic [SYM_W-1:0] CH_NL    = 9'h00A;
   localparam logic [SYM_W-1:0] CH_TAB   = 9'h009;
   localparam logic [SYM_W-1:0] CH_CR    = 9'h00D;
   localparam logic [SYM_W-1:0] CH_SP    = 9'h020;
   localparam logic [SYM_W-1:0] CH_BANG  = 9'h021;
   localparam logic [SYM_W-1:0] CH_QUOTE = 9'h022;
   localparam logic [SYM_W-1:0] CH_LPAR  = 9'h028;
   localparam logic [SYM_W-1:0] CH_RPAR  = 9'h029;
   localparam logic [SYM_W-1:0] CH_STAR  = 9'h02A;
   localparam logic [SYM_W-1:0] CH_PLUS  = 9'h02B;
   localparam logic [SYM_W-1:0] CH_COMMA = 9'h02C;
   localparam logic [SYM_W-1:0] CH_MINUS = 9'h02D;
   localparam logic [SYM_W-1:0] CH_DOT   = 9'h02E;
   localparam logic [SYM_W-1:0] CH_SLASH = 9'h02F;
   localparam logic [SYM_W-1:0] CH_D0    = 9'h030;
   localparam logic [SYM_W-1:0] CH_D9    = 9'h039;
   localparam logic [SYM_W-1:0] CH_COLON = 9'h03A;
   localparam logic [SYM_W-1:0] CH_SEMI  = 9'h03B;
   localparam logic [SYM_W-1:0] CH_LT    = 9'h03C;
   localparam logic [SYM_W-1:0] CH_EQ    = 9'h03D;
   localparam logic [SYM_W-1:0] CH_GT    = 9'h03E;
   localparam logic [SYM_W-1:0] CH_UA    = 9'h041;
   localparam logic [SYM_W-1:0] CH_UZ    = 9'h05A;
   localparam logic [SYM_W-1:0] CH_LBRK  = 9'h05B;
   localparam logic [SYM_W-1:0] CH_BSL   = 9'h05C;
   localparam logic [SYM_W-1:0] CH_RBRK  = 9'h05D;
   localparam logic [SYM_W-1:0] CH_UND   = 9'h05F;
   localparam logic [SYM_W-1:0] CH_LA    = 9'h061;
   localparam logic [SYM_W-1:0] CH_LZ    = 9'h07A;
   localparam logic [SYM_W-1:0] CH_LCB   = 9'h07B;
   localparam logic [SYM_W-1:0] CH_RCB   = 9'h07D;

   // Keyword trie: character, parent node (ROOT for first letters), kind.
   localparam logic [7:0] ROOT = 8'hFF;

   localparam logic [7:0] TRIE_CH [TRIE_N] = '{
      "i","f","n",
      "e","l","s","e","n","d",
      "n","o","t","i","l",
      "a","n","d",
      "o","r",
      "t","r","u","e","o",
      "f","a","l","s","e","o","r",
      "d","e","f",
      "w","h","i","l","e",
      "r","e","t","u","r","n",
      "b","r","e","a","k",
      "c","o","n","t","i","n","u","e"};

   localparam logic [7:0] TRIE_PAR [TRIE_N] = '{
      8'hFF, 8'd0, 8'd0,
      8'hFF, 8'd3, 8'd4, 8'd5, 8'd3, 8'd7,
      8'hFF, 8'd9, 8'd10, 8'd9, 8'd12,
      8'hFF, 8'd14, 8'd15,
      8'hFF, 8'd17,
      8'hFF, 8'd19, 8'd20, 8'd21, 8'd19,
      8'hFF, 8'd24, 8'd25, 8'd26, 8'd27, 8'd24, 8'd29,
      8'hFF, 8'd31, 8'd32,
      8'hFF, 8'd34, 8'd35, 8'd36, 8'd37,
      8'hFF, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43,
      8'hFF, 8'd45, 8'd46, 8'd47, 8'd48,
      8'hFF, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56};

   localparam logic [KIND_W-1:0] TRIE_KIND [TRIE_N] = '{
      6'd4, 6'd5, 6'd6,
      6'd4, 6'd4, 6'd4, 6'd7, 6'd4, 6'd8,
      6'd4, 6'd4, 6'd9, 6'd4, 6'd10,
      6'd4, 6'd4, 6'd11,
      6'd4, 6'd12,
      6'd4, 6'd4, 6'd4, 6'd13, 6'd14,
      6'd4, 6'd4, 6'd4, 6'd4, 6'd15, 6'd4, 6'd16,
      6'd4, 6'd4, 6'd17,
      6'd4, 6'd4, 6'd4, 6'd4, 6'd18,
      6'd4, 6'd4, 6'd4, 6'd4, 6'd4, 6'd19,
      6'd4, 6'd4, 6'd4, 6'd4, 6'd20,
      6'd4, 6'd4, 6'd4, 6'd4, 6'd4, 6'd4, 6'd4, 6'd21};

   // One result token.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [INT_W-1:0]  int_value;
      logic [FRAC_W-1:0] frac_value;
      logic [FCNT_W-1:0] frac_digits;
      logic [LINE_W-1:0] line_number;
      logic [BAD_W-1:0]  bad_byte;
      logic              last;
   } token_type;

   // Queue status seen by the top level.
   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              room;
   } queue_status_type;

   function automatic logic is_digit(input logic [SYM_W-1:0] c);
      return (c >= CH_D0) && (c <= CH_D9);
   endfunction

   function automatic logic is_ident(input logic [SYM_W-1:0] c);
      return is_digit(c) || ((c >= CH_LA) && (c <= CH_LZ)) ||
             ((c >= CH_UA) && (c <= CH_UZ)) || (c == CH_UND);
   endfunction

   // Child lookup: {found, node index}. All entries are compared in parallel.
   function automatic logic [NODE_W:0] trie_find(input logic [7:0] parent,
                                                 input logic [SYM_W-1:0] c);
      logic [NODE_W:0] r;
      r = '0;
      for (int i = 0; i < TRIE_N; i++) begin
         if ((TRIE_PAR[i] == parent) && ({1'b0, TRIE_CH[i]} == c)) begin
            r = {1'b1, NODE_W'(i)};
         end
      end
      return r;
   endfunction

endpackage

// ===== sv/keyword_tokenizer_dfa_unit.sv =====
// ----------------------------------------------------------------------------
// keyword_tokenizer_dfa_unit: byte-serial keyword tokenizer
// Scans source bytes and emits tokens with line and number values.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one source byte per transaction in req_tdata,
//   with req_tuser high to mark end of input (the byte is then ignored).
//   The response channel carries one token per transaction; rsp_tlast is
//   high on the last token caused by a request.
//   A request is registered on acceptance and scanned once the queue has room
//   for three tokens; then all its tokens (zero to three) are written into a
//   four-entry token queue in one step. The first token shows on rsp_tvalid
//   once the queue has registered that step, so a token passes the input
//   register and the queue before the receiver can take it.
//   One request is taken per cycle while the queue holds at most one token,
//   so with one token or less per request and a ready receiver the rate is
//   one request per cycle; requests that yield two or three tokens hold back
//   later requests until the queue drains to one token, one token per cycle.
//   When the receiver stalls, the queue fills and req_tready drops; nothing
//   is lost. Reset empties the queue and the input register, puts the
//   scanner in its start state with line count one and zero accumulators.
// ----------------------------------------------------------------------------
module keyword_tokenizer_dfa_unit import kdfa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] input_byte
   input  logic         req_tuser,   // [0] end_of_input
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [5:0] token_kind, [36:6] int_value,
                                     // [66:37] frac_value, [70:67] frac_digits,
                                     // [94:71] line_number, [103:95] bad_byte
   output logic         rsp_tlast    // last token of the request
);

   logic                    in_valid_ff;
   logic [SYM_W-1:0]        sym_ff;
   logic                    fire;
   token_type [MAX_TOK-1:0] toks;
   logic [1:0]              tok_count;
   logic [LINE_W-1:0]       line_now;
   token_type               head;
   queue_status_type        qstat;
   logic                    pop;

   assign fire       = in_valid_ff && qstat.room;
   assign req_tready = !in_valid_ff || fire;
   assign pop        = rsp_tvalid && rsp_tready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         sym_ff <= req_tuser ? CH_EOI : {1'b0, req_tdata};
      end
   end

   kdfa_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .sym       (sym_ff),
      .toks      (toks),
      .tok_count (tok_count),
      .line_now  (line_now)
   );

   kdfa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (fire),
      .push_toks  (toks),
      .push_count (tok_count),
      .pop        (pop),
      .head       (head),
      .not_empty  (rsp_tvalid),
      .status     (qstat)
   );

   // Response packing.
   assign rsp_tdata = {head.bad_byte, head.line_number, head.frac_digits,
                       head.frac_value, head.int_value, head.kind};
   assign rsp_tlast = head.last;

   // The queue never holds more tokens than it has entries.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qstat.count <= QCNT_W'(QDEPTH))
      else $error("token queue overflow");

   // A scan step only happens with room for a full item.
   a_fire_room: assert property (@(posedge clock) disable iff (reset)
      fire |-> qstat.count <= QCNT_W'(QDEPTH - MAX_TOK))
      else $error("scan step without queue room");

   // The line count starts at one and never wraps to zero.
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_now != '0)
      else $error("line count is zero");

endmodule

// ===== sv/kdfa_scan.sv =====
// ----------------------------------------------------------------------------
// kdfa_scan: scanner state and token step
// Holds scan state, line count and number accumulators. For one symbol it
// runs the scan step and, where the ending symbol must be seen again, the
// start-state step, producing up to three tokens in the same cycle.
// ----------------------------------------------------------------------------
module kdfa_scan import kdfa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [SYM_W-1:0]      sym,
   output token_type [MAX_TOK-1:0] toks,
   output logic [1:0]            tok_count,
   output logic [LINE_W-1:0]     line_now
);

   logic [STATE_W-1:0] state_ff, state_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic [INT_W-1:0]   int_ff, int_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [FCNT_W-1:0]  fcnt_ff, fcnt_in;

   // Start-state step results.
   logic [STATE_W-1:0] st_state;
   logic               st_emit;
   logic [KIND_W-1:0]  st_kind;
   logic [BAD_W-1:0]   st_bad;
   logic               st_nl;
   logic               st_digit;
   logic [NODE_W:0]    root_hit;

   // Scan step results.
   logic [STATE_W-1:0] p1_state;
   logic               rescan;
   logic [1:0]         p1_n;
   logic [KIND_W-1:0]  p1_k0, p1_k1;
   logic [BAD_W-1:0]   p1_b0;
   logic               p1_nl;
   logic               p1_int_digit;
   logic               p1_frac_digit;
   logic [NODE_W:0]    node_hit;
   logic [NODE_W-1:0]  node;
   logic               in_trie;

   // Arithmetic helpers.
   logic [3:0]         dval;
   logic [INT_W+3:0]   int_mul;
   logic [FRAC_W+3:0]  frac_mul;
   logic [LINE_W-1:0]  line_inc;
   logic               do_nl;

   assign dval     = sym[3:0];
   assign int_mul  = ({4'd0, int_ff} << 3) + ({4'd0, int_ff} << 1) + (INT_W+4)'(dval);
   assign frac_mul = ({4'd0, frac_ff} << 3) + ({4'd0, frac_ff} << 1) + (FRAC_W+4)'(dval);
   assign line_inc = (line_ff == LINE_MAX) ? line_ff : line_ff + 1'b1;
   assign line_now = line_ff;

   // Start-state step.
   assign root_hit = trie_find(ROOT, sym);
   always_comb begin
      st_state = S_START;
      st_emit  = 1'b0;
      st_kind  = K_ERROR;
      st_bad   = '0;
      st_nl    = 1'b0;
      st_digit = 1'b0;
      if (sym == CH_EOI) begin
         st_emit = 1'b1;
         st_kind = K_EOS;
      end else if (sym == CH_SP || sym == CH_TAB || sym == CH_CR) begin
         st_emit = 1'b0;
      end else if (sym == CH_NL) begin
         st_nl   = 1'b1;
         st_emit = 1'b1;
         st_kind = K_NEWLINE;
      end else if (sym == CH_QUOTE) begin
         st_state = S_STRING;
      end else if (is_digit(sym)) begin
         st_digit = 1'b1;
         st_state = S_INT;
      end else if (root_hit[NODE_W]) begin
         st_state = S_TRIE + STATE_W'(root_hit[NODE_W-1:0]);
      end else if (is_ident(sym)) begin
         st_state = S_IDENT;
      end else begin
         case (sym)
            CH_PLUS:  st_state = S_PLUS;
            CH_MINUS: st_state = S_MINUS;
            CH_STAR:  st_state = S_STAR;
            CH_SLASH: st_state = S_SLASH;
            CH_BSL:   st_state = S_BSLASH;
            CH_EQ:    st_state = S_EQ;
            CH_GT:    st_state = S_GT;
            CH_LT:    st_state = S_LT;
            CH_BANG:  st_state = S_BANG;
            CH_LPAR:  begin st_emit = 1'b1; st_kind = K_LPAR;   end
            CH_RPAR:  begin st_emit = 1'b1; st_kind = K_RPAR;   end
            CH_LBRK:  begin st_emit = 1'b1; st_kind = K_LBRK;   end
            CH_RBRK:  begin st_emit = 1'b1; st_kind = K_RBRK;   end
            CH_LCB:   begin st_emit = 1'b1; st_kind = K_LBRACE; end
            CH_RCB:   begin st_emit = 1'b1; st_kind = K_RBRACE; end
            CH_DOT:   begin st_emit = 1'b1; st_kind = K_DOT;    end
            CH_COMMA: begin st_emit = 1'b1; st_kind = K_COMMA;  end
            CH_COLON: begin st_emit = 1'b1; st_kind = K_COLON;  end
            CH_SEMI:  begin st_emit = 1'b1; st_kind = K_SEMI;   end
            default:  begin st_emit = 1'b1; st_kind = K_ERROR; st_bad = sym; end
         endcase
      end
   end

   // Scan step from the current state.
   assign in_trie  = (state_ff >= S_TRIE) && (state_ff < S_TRIE_END);
   assign node     = NODE_W'(state_ff - S_TRIE);
   assign node_hit = trie_find({2'b00, node}, sym);

   always_comb begin
      p1_state      = S_START;
      rescan        = 1'b0;
      p1_n          = 2'd0;
      p1_k0         = K_ERROR;
      p1_k1         = K_DOT;
      p1_b0         = '0;
      p1_nl         = 1'b0;
      p1_int_digit  = 1'b0;
      p1_frac_digit = 1'b0;
      if (in_trie) begin
         if (node_hit[NODE_W]) begin
            p1_state = S_TRIE + STATE_W'(node_hit[NODE_W-1:0]);
         end else if (is_ident(sym)) begin
            p1_state = S_IDENT;
         end else begin
            p1_n   = 2'd1;
            p1_k0  = TRIE_KIND[node];
            rescan = 1'b1;
         end
      end else begin
         case (state_ff)
            S_START: begin
               p1_state = st_state;
            end
            S_STRING: begin
               if (sym == CH_QUOTE) begin
                  p1_n  = 2'd1;
                  p1_k0 = K_STRING;
               end else if (sym == CH_EOI) begin
                  p1_n   = 2'd1;
                  p1_k0  = K_ERROR;
                  p1_b0  = CH_EOI;
                  rescan = 1'b1;
               end else begin
                  p1_state = S_STRING;
                  p1_nl    = (sym == CH_NL);
               end
            end
            S_INT: begin
               if (sym == CH_DOT) begin
                  p1_state = S_INT_DOT;
               end else if (is_digit(sym)) begin
                  p1_state     = S_INT;
                  p1_int_digit = 1'b1;
               end else begin
                  p1_n   = 2'd1;
                  p1_k0  = K_INTEGER;
                  rescan = 1'b1;
               end
            end
            S_INT_DOT: begin
               if (is_digit(sym)) begin
                  p1_state      = S_FRAC;
                  p1_frac_digit = 1'b1;
               end else begin
                  // Integer followed by a lone dot.
                  p1_n   = 2'd2;
                  p1_k0  = K_INTEGER;
                  p1_k1  = K_DOT;
                  rescan = 1'b1;
               end
            end
            S_FRAC: begin
               if (is_digit(sym)) begin
                  p1_state      = S_FRAC;
                  p1_frac_digit = 1'b1;
               end else begin
                  p1_n   = 2'd1;
                  p1_k0  = K_DECIMAL;
                  rescan = 1'b1;
               end
            end
            S_IDENT: begin
               if (is_ident(sym)) begin
                  p1_state = S_IDENT;
               end else begin
                  p1_n   = 2'd1;
                  p1_k0  = K_IDENT;
                  rescan = 1'b1;
               end
            end
            S_EQ, S_GT, S_LT, S_PLUS, S_MINUS, S_STAR: begin
               p1_n = 2'd1;
               case (state_ff)
                  S_EQ:    p1_k0 = (sym == CH_EQ) ? K_EQ     : K_ASSIGN;
                  S_GT:    p1_k0 = (sym == CH_EQ) ? K_GE     : K_GT;
                  S_LT:    p1_k0 = (sym == CH_EQ) ? K_LE     : K_LT;
                  S_PLUS:  p1_k0 = (sym == CH_EQ) ? K_ADD_EQ : K_ADD;
                  S_MINUS: p1_k0 = (sym == CH_EQ) ? K_SUB_EQ : K_SUB;
                  default: p1_k0 = (sym == CH_EQ) ? K_MUL_EQ : K_MUL;
               endcase
               rescan = (sym != CH_EQ);
            end
            S_BANG: begin
               p1_n = 2'd1;
               if (sym == CH_EQ) begin
                  p1_k0 = K_NE;
               end else begin
                  p1_k0  = K_ERROR;
                  p1_b0  = sym;
                  rescan = 1'b1;
               end
            end
            S_SLASH: begin
               if (sym == CH_SLASH) begin
                  p1_state = S_LINE_CMT;
               end else if (sym == CH_STAR) begin
                  p1_state = S_BLK;
               end else if (sym == CH_EQ) begin
                  p1_n  = 2'd1;
                  p1_k0 = K_DIV_EQ;
               end else begin
                  p1_n   = 2'd1;
                  p1_k0  = K_DIV;
                  rescan = 1'b1;
               end
            end
            S_LINE_CMT: begin
               if (sym == CH_NL || sym == CH_EOI) begin
                  rescan = 1'b1;
               end else begin
                  p1_state = S_LINE_CMT;
               end
            end
            S_BLK, S_BLK_STAR: begin
               if (sym == CH_EOI) begin
                  rescan = 1'b1;
               end else if (sym == CH_STAR) begin
                  p1_state = S_BLK_STAR;
               end else if (sym == CH_SLASH && state_ff == S_BLK_STAR) begin
                  p1_state = S_START;
               end else begin
                  p1_state = S_BLK;
                  p1_nl    = (sym == CH_NL);
               end
            end
            S_BSLASH: begin
               if (sym == CH_NL) begin
                  p1_nl = 1'b1;
               end else begin
                  p1_n   = 2'd1;
                  p1_k0  = K_ERROR;
                  p1_b0  = sym;
                  rescan = 1'b1;
               end
            end
            default: begin
               rescan = 1'b1;
            end
         endcase
      end
   end

   // Assemble the token list and next state.
   always_comb begin
      logic [KIND_W-1:0] k [MAX_TOK];
      logic [BAD_W-1:0]  b [MAX_TOK];
      logic              use_start;
      logic [1:0]        n;
      use_start = rescan || (state_ff == S_START && !in_trie);
      k[0] = p1_k0;
      b[0] = p1_b0;
      k[1] = p1_k1;
      b[1] = '0;
      k[2] = st_kind;
      b[2] = st_bad;
      n    = p1_n;
      if (use_start && st_emit) begin
         k[n] = st_kind;
         b[n] = st_bad;
         n    = n + 2'd1;
      end
      tok_count = n;
      for (int i = 0; i < MAX_TOK; i++) begin
         toks[i].kind        = k[i];
         toks[i].int_value   = (k[i] == K_INTEGER || k[i] == K_DECIMAL) ? int_ff : '0;
         toks[i].frac_value  = (k[i] == K_DECIMAL) ? frac_ff : '0;
         toks[i].frac_digits = (k[i] == K_DECIMAL) ? fcnt_ff : '0;
         toks[i].line_number = (k[i] == K_NEWLINE) ? line_inc : line_ff;
         toks[i].bad_byte    = (k[i] == K_ERROR) ? b[i] : '0;
         toks[i].last        = (2'(i) == n - 2'd1);
      end

      // Next state and accumulators.
      state_in = rescan ? st_state : p1_state;
      do_nl    = p1_nl || (use_start && st_nl);
      line_in  = do_nl ? line_inc : line_ff;
      int_in   = int_ff;
      frac_in  = frac_ff;
      fcnt_in  = fcnt_ff;
      if (use_start && st_digit) begin
         int_in  = INT_W'(dval);
         frac_in = '0;
         fcnt_in = '0;
      end else if (p1_int_digit) begin
         int_in = (int_mul > {4'd0, INT_MAX}) ? INT_MAX : int_mul[INT_W-1:0];
      end else if (p1_frac_digit && fcnt_ff < FCNT_W'(FRAC_DIGITS_MAX)) begin
         frac_in = frac_mul[FRAC_W-1:0];
         fcnt_in = fcnt_ff + 1'b1;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_START;
         line_ff  <= LINE_W'(1);
         int_ff   <= '0;
         frac_ff  <= '0;
         fcnt_ff  <= '0;
      end else if (fire) begin
         state_ff <= state_in;
         line_ff  <= line_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         fcnt_ff  <= fcnt_in;
      end
   end

endmodule

// ===== sv/kdfa_queue.sv =====
// ----------------------------------------------------------------------------
// kdfa_queue: token queue
// Four-entry queue that takes up to three tokens in one cycle and hands them
// out one per transaction on the result side.
// ----------------------------------------------------------------------------
module kdfa_queue import kdfa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  token_type [MAX_TOK-1:0] push_toks,
   input  logic [1:0]              push_count,
   input  logic                    pop,
   output token_type               head,
   output logic                    not_empty,
   output queue_status_type        status
);

   token_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wp_ff, wp_in;
   logic [QPTR_W-1:0] rp_ff, rp_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]        n_push;

   assign n_push       = push ? push_count : 2'd0;
   assign head         = mem_ff[rp_ff];
   assign not_empty    = (cnt_ff != '0);
   assign status.count = cnt_ff;
   // Room for a full three-token item.
   assign status.room  = (cnt_ff <= QCNT_W'(QDEPTH - MAX_TOK));

   // Pointer and count update.
   always_comb begin
      wp_in  = wp_ff + QPTR_W'(n_push);
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + QCNT_W'(n_push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Token storage.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_TOK; i++) begin
         if (2'(i) < n_push) begin
            mem_ff[wp_ff + QPTR_W'(i)] <= push_toks[i];
         end
      end
   end

endmodule
